// ===== rtl/ptpo_pkg.sv =====
// Shared types, constants and the octave root table of the pitch-to-phase oscillator.
package ptpo_pkg;

  localparam int VoicesDefault = 8;
  localparam int RootSteps     = 12;
  localparam logic [22:0] FreqMax = 23'd5120000;

  localparam logic [2:0] REG_TUNE_BASE = 3'd0;
  localparam logic [2:0] REG_FREQ_MULT = 3'd1;
  localparam logic [2:0] REG_FREQ_OFFS = 3'd2;
  localparam logic [2:0] REG_INC_PER_HZ = 3'd3;

  typedef struct packed {
    logic [2:0]         voice;
    logic signed [15:0] pitch_voltage;
    logic signed [31:0] phase_mod;
    logic               gate_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  voice_out;
    logic [31:0] phase_out;
    logic [22:0] frequency_hz;
    logic        freq_clamped;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  reg_idx;
    logic [31:0] wdata;
  } cfg_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROOT, ST_MULA, ST_MULX, ST_SHIFT, ST_CLAMP, ST_INC, ST_DONE
  } ptpo_state_e;

  typedef struct packed {
    logic load;
    logic root_step;
    logic mula;
    logic mulx;
    logic shift;
    logic clamp;
    logic inc;
    logic finish;
  } ptpo_cmd_t;

  typedef struct packed {
    logic root_last;
    logic out_free;
  } ptpo_sts_t;

  // 2^(2^-j) in Q1.30, by repeated floor square roots starting from 2.
  function automatic logic [30:0] root_val(input int j);
    longint unsigned x;
    longint unsigned n;
    longint unsigned r;
    longint unsigned b;
    int i;
    x = 64'd1 << 31;
    for (i = 0; i < j; i++) begin
      n = x << 30;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 64'd0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      x = r;
    end
    return x[30:0];
  endfunction

  // Indexed by fraction bit b; entry b holds 2^(2^(b-12)).
  localparam logic [30:0] ROOT_BY_BIT [RootSteps] = '{
    root_val(12), root_val(11), root_val(10), root_val(9), root_val(8), root_val(7),
    root_val(6), root_val(5), root_val(4), root_val(3), root_val(2), root_val(1)
  };

endpackage

// ===== rtl/ptpo_chan_if.sv =====
// Valid/ready channel carrying one payload per transaction.
interface ptpo_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ptpo_ctrl.sv =====
// Sequencer that steps the oscillator datapath through one voice sample.
module ptpo_ctrl import ptpo_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ptpo_sts_t sts_i,
  output ptpo_cmd_t cmd_o
);

  ptpo_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_ROOT;
      ST_ROOT:  if (sts_i.root_last) state_d = ST_MULA;
      ST_MULA:  state_d = ST_MULX;
      ST_MULX:  state_d = ST_SHIFT;
      ST_SHIFT: state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_INC;
      ST_INC:   state_d = ST_DONE;
      ST_DONE:  if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_ROOT:  cmd_o.root_step = 1'b1;
      ST_MULA:  cmd_o.mula = 1'b1;
      ST_MULX:  cmd_o.mulx = 1'b1;
      ST_SHIFT: cmd_o.shift = 1'b1;
      ST_CLAMP: cmd_o.clamp = 1'b1;
      ST_INC:   cmd_o.inc = 1'b1;
      ST_DONE:  cmd_o.finish = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/ptpo_dp.sv =====
// Oscillator datapath: settings, per-voice phase store, frequency and phase arithmetic.
module ptpo_dp import ptpo_pkg::*; #(
  parameter int VOICES = VoicesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  logic      cfg_valid_i,
  input  cfg_wr_t   cfg_data_i,
  input  ptpo_cmd_t cmd_i,
  output ptpo_sts_t sts_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int IdxW = (VOICES > 1) ? $clog2(VOICES) : 1;

  logic [19:0] tune_q;
  logic [14:0] mult_q;
  logic [16:0] offs_q;
  logic [31:0] incr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tune_q <= 20'd56320;
      mult_q <= 15'd256;
      offs_q <= 17'd0;
      incr_q <= 32'd22906492;
    end else if (cfg_valid_i) begin
      case (cfg_data_i.reg_idx)
        REG_TUNE_BASE:  tune_q <= cfg_data_i.wdata[19:0];
        REG_FREQ_MULT:  mult_q <= cfg_data_i.wdata[14:0];
        REG_FREQ_OFFS:  offs_q <= cfg_data_i.wdata[16:0];
        REG_INC_PER_HZ: incr_q <= cfg_data_i.wdata;
        default: ;
      endcase
    end
  end

  // Item registers.
  logic [2:0]     voice_q;
  logic [15:0]    pv_q;
  logic [31:0]    pmod_q;
  logic           gate_q;
  logic           present_q;
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] idx_in;

  assign idx_in = IdxW'(in_data_i.voice);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      voice_q   <= in_data_i.voice;
      pv_q      <= in_data_i.pitch_voltage;
      pmod_q    <= in_data_i.phase_mod;
      gate_q    <= in_data_i.gate_in;
      present_q <= 32'(in_data_i.voice) < VOICES;
      idx_q     <= idx_in;
    end
  end

  // Per-voice store: phase memory with valid bits, and gate levels.
  logic [31:0]       phase_mem [VOICES];
  logic [VOICES-1:0] vld_q;
  logic [VOICES-1:0] gate_lvl_q;
  logic [31:0]       rd_phase_q;
  logic              rd_vld_q;
  logic              rd_gate_q;
  logic [31:0]       new_phase;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_phase_q <= phase_mem[idx_in];
    end
    if (cmd_i.finish && present_q) begin
      phase_mem[idx_q] <= new_phase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      gate_lvl_q <= '0;
      rd_vld_q   <= 1'b0;
      rd_gate_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rd_vld_q  <= vld_q[idx_in];
        rd_gate_q <= gate_lvl_q[idx_in];
      end
      if (cmd_i.finish && present_q) begin
        vld_q[idx_q]      <= 1'b1;
        gate_lvl_q[idx_q] <= gate_q;
      end
    end
  end

  // Mantissa: one root multiply per fraction bit.
  logic [3:0]  bit_q;
  logic [30:0] m_q;
  logic [62:0] m_prod;

  assign m_prod = 63'(m_q * ROOT_BY_BIT[bit_q]) + (63'd1 << 29);
  assign sts_o.root_last = (bit_q == 4'(RootSteps - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q   <= 31'd1 << 30;
      bit_q <= '0;
    end else if (cmd_i.root_step) begin
      if (pv_q[bit_q]) m_q <= m_prod[60:30];
      bit_q <= bit_q + 4'd1;
    end
  end

  // Scaling chain.
  logic [29:0] a_q;
  logic [44:0] x_q;
  logic [36:0] y_q;
  logic [22:0] freq_q;
  logic        clamped_q;
  logic [31:0] inc_q;
  logic [51:0] a_prod;
  logic [3:0]  shamt;
  logic [60:0] x_shift;
  logic signed [38:0] sum_s;
  logic [55:0] inc_prod;

  assign a_prod   = 52'(tune_q * m_q) + (52'd1 << 21);
  // Shifting by k+8 and rounding at bit 24 covers both signs of the octave.
  assign shamt    = {~pv_q[15], pv_q[14:12]};
  assign x_shift  = (61'(x_q) << shamt) + (61'd1 << 23);
  assign sum_s    = $signed({2'b00, y_q}) + 39'($signed(offs_q));
  assign inc_prod = 56'(freq_q * incr_q) + (56'd1 << 15);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mula) a_q <= a_prod[51:22];
    if (cmd_i.mulx) x_q <= 45'(a_q * mult_q);
    if (cmd_i.shift) y_q <= x_shift[60:24];
    if (cmd_i.clamp) begin
      if (sum_s < 0) begin
        freq_q    <= '0;
        clamped_q <= 1'b1;
      end else if (sum_s > $signed({16'd0, FreqMax})) begin
        freq_q    <= FreqMax;
        clamped_q <= 1'b1;
      end else begin
        freq_q    <= sum_s[22:0];
        clamped_q <= 1'b0;
      end
    end
    if (cmd_i.inc) inc_q <= inc_prod[47:16];
  end

  // Effective phase: cleared on a rising gate, zero for an unwritten or absent voice.
  logic [31:0] iphase;

  always_comb begin
    iphase = '0;
    if (present_q && rd_vld_q && !(gate_q && !rd_gate_q)) iphase = rd_phase_q;
  end

  assign new_phase = iphase + inc_q;

  // Output register.
  logic      out_vld_q;
  out_item_t out_q;

  assign sts_o.out_free = !out_vld_q || out_ready_i;
  assign out_valid_o    = out_vld_q;
  assign out_data_o     = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.voice_out    <= voice_q;
      out_q.phase_out    <= pmod_q + iphase;
      out_q.frequency_hz <= freq_q;
      out_q.freq_clamped <= clamped_q;
    end
  end

endmodule

// ===== rtl/pitch_to_phase_oscillator_core_unit.sv =====
// Multi-voice pitch-to-phase oscillator: one voice sample per transaction.
// After an item is accepted, the shared root multiplier builds 2^fraction, one bit of
// the voltage fraction per step, followed by the base-tune multiply, the multiplier
// multiply, the octave shift, the offset and clamp, the phase-increment multiply and
// a final update of the voice's phase store, made once the output register is free,
// as the result is written to the output register. A new item is accepted in the cycle
// after the result is written to the output register, so the block takes no new item
// while one is in progress; a waiting result does not block the next item until that
// item is finished. Configuration writes are taken in any cycle and must only be
// issued while the block is idle.
module pitch_to_phase_oscillator_core_unit import ptpo_pkg::*; #(
  parameter int VOICES = VoicesDefault
) (
  input logic  clk_i,
  input logic  rst_ni,
  ptpo_chan_if.sink   in_i,
  ptpo_chan_if.sink   cfg_i,
  ptpo_chan_if.source out_o
);

  ptpo_cmd_t cmd;
  ptpo_sts_t sts;

  assign cfg_i.ready = 1'b1;

  ptpo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptpo_dp #(
    .VOICES (VOICES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

// ===== test/tb_pitch_to_phase_oscillator_core_unit.sv =====
// Testbench for the pitch-to-phase oscillator core: random and directed voice samples.
module tb_pitch_to_phase_oscillator_core_unit import ptpo_pkg::*; ();

  // Expected results in order, plus the oscillator state that produces them.
  class phase_scoreboard;
    out_item_t pending[$];
    int unsigned mismatches;
    logic [19:0] tune_base;
    logic [14:0] mult;
    logic [16:0] offs;
    logic [31:0] inc_per_hz;
    logic [31:0] voice_phase[8];
    logic voice_gate[8];
    longint unsigned roots[13];

    function new();
      longint unsigned x, n, r, b;
      int j;
      tune_base = 20'd56320;
      mult = 15'd256;
      offs = 17'd0;
      inc_per_hz = 32'd22906492;
      mismatches = 0;
      for (j = 0; j < 8; j++) begin
        voice_phase[j] = '0;
        voice_gate[j] = 1'b0;
      end
      // Successive floor square roots of two in Q1.30.
      x = 64'd1 << 31;
      for (j = 1; j <= 12; j++) begin
        n = x << 30;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
          if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
          b = b >> 2;
        end
        x = r;
        roots[j] = x;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_TUNE_BASE: tune_base = val[19:0];
        REG_FREQ_MULT: mult = val[14:0];
        REG_FREQ_OFFS: offs = val[16:0];
        REG_INC_PER_HZ: inc_per_hz = val;
        default: ;
      endcase
    endfunction

    function void note_sample(in_item_t it);
      int octave;
      logic [11:0] frac;
      longint unsigned mant, a, x, y, prod;
      longint sum;
      out_item_t res;
      logic [31:0] step, iph;
      int b;
      octave = int'({1'b0, ~it.pitch_voltage[15], it.pitch_voltage[14:12]}) - 8;
      frac = it.pitch_voltage[11:0];
      mant = 64'd1 << 30;
      for (b = 0; b < 12; b++)
        if (frac[b]) mant = (mant * roots[12 - b] + (64'd1 << 29)) >> 30;
      a = (longint'(tune_base) * mant + (64'd1 << 21)) >> 22;
      x = a * longint'(mult);
      if (octave >= 0) y = ((x << octave) + (64'd1 << 15)) >> 16;
      else y = (x + (64'd1 << (15 - octave))) >> (16 - octave);
      sum = longint'(y) + longint'($signed(offs));
      res.freq_clamped = 1'b0;
      if (sum < 0) begin
        sum = 0;
        res.freq_clamped = 1'b1;
      end else if (sum > 5120000) begin
        sum = 5120000;
        res.freq_clamped = 1'b1;
      end
      res.frequency_hz = sum[22:0];
      prod = longint'(sum) * longint'(inc_per_hz) + (64'd1 << 15);
      step = prod[47:16];
      if (it.gate_in && !voice_gate[it.voice]) voice_phase[it.voice] = '0;
      voice_gate[it.voice] = it.gate_in;
      iph = voice_phase[it.voice];
      voice_phase[it.voice] = iph + step;
      res.voice_out = it.voice;
      res.phase_out = it.phase_mod + iph;
      pending.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("expected %p got %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  ptpo_chan_if #(.payload_t(in_item_t)) in_ch ();
  ptpo_chan_if #(.payload_t(cfg_wr_t)) cfg_ch ();
  ptpo_chan_if #(.payload_t(out_item_t)) out_ch ();
  phase_scoreboard sb = new();
  bit idle_off = 1'b0;

  pitch_to_phase_oscillator_core_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .cfg_i(cfg_ch.sink), .out_o(out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: random stall bursts, checks every transaction.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if (!idle_off && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 18);
        repeat (n) begin
          @(posedge clk_i);
        end
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // The input valid stays high between back-to-back samples unless a random gap lowers it; drain lowers it.
  task automatic send_sample(in_item_t it);
    int n;
    cfg_ch.valid <= 1'b0;
    if (!idle_off && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      n = $urandom_range(1, 18);
      repeat (n) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_sample(it);
  endtask

  // The write valid stays high between back-to-back writes; send_sample lowers it.
  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{reg_idx: idx, wdata: val};
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  function automatic in_item_t rand_sample();
    in_item_t it;
    it.voice = 3'($urandom_range(0, 7));
    it.pitch_voltage = 16'($urandom);
    if ($urandom_range(0, 2) == 0) it.pitch_voltage = 16'($signed($urandom_range(0, 8191)) - 4096);
    it.phase_mod = $urandom;
    it.gate_in = $urandom_range(0, 3) != 0;
    return it;
  endfunction

  initial begin
    in_item_t it;
    int ph, i;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: voltage extremes, phase offset extremes, gate edges, bad register index.
    it = '{voice: 3'd0, pitch_voltage: 16'sh8000, phase_mod: 32'sh8000_0000, gate_in: 1'b1};
    send_sample(it);
    it = '{voice: 3'd0, pitch_voltage: 16'sh7fff, phase_mod: 32'sh7fff_ffff, gate_in: 1'b1};
    send_sample(it);
    it = '{voice: 3'd0, pitch_voltage: 16'sh0000, phase_mod: 32'sh0, gate_in: 1'b0};
    send_sample(it);
    it = '{voice: 3'd0, pitch_voltage: 16'sh0fff, phase_mod: -32'sd1, gate_in: 1'b1};
    send_sample(it);
    it = '{voice: 3'd7, pitch_voltage: 16'shf000, phase_mod: 32'sh1234_5678, gate_in: 1'b0};
    send_sample(it);
    it = '{voice: 3'd7, pitch_voltage: 16'sh1800, phase_mod: 32'sh0, gate_in: 1'b0};
    send_sample(it);
    drain();
    write_cfg(3'd5, 32'hffff_ffff);
    write_cfg(REG_FREQ_OFFS, 32'h1_3800);
    it = '{voice: 3'd3, pitch_voltage: 16'shc000, phase_mod: 32'sh0, gate_in: 1'b1};
    send_sample(it);
    drain();
    for (ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          write_cfg(REG_TUNE_BASE, 32'hf_ffff);
          write_cfg(REG_FREQ_MULT, 32'd16384);
          write_cfg(REG_FREQ_OFFS, 32'd51200);
          write_cfg(REG_INC_PER_HZ, 32'hffff_ffff);
        end
        1: begin
          write_cfg(REG_TUNE_BASE, 32'd0);
          write_cfg(REG_FREQ_MULT, 32'd0);
          write_cfg(REG_FREQ_OFFS, 32'h1_3800);
          write_cfg(REG_INC_PER_HZ, 32'd0);
        end
        2: begin
          write_cfg(REG_TUNE_BASE, 32'h7fff);
          write_cfg(REG_FREQ_MULT, 32'h7fff);
          write_cfg(REG_FREQ_OFFS, 32'h1_ffff);
          write_cfg(REG_INC_PER_HZ, $urandom);
        end
        default: begin
          write_cfg(REG_TUNE_BASE, $urandom_range(0, 20'hf_ffff));
          write_cfg(REG_FREQ_MULT, $urandom_range(0, 16384));
          write_cfg(REG_FREQ_OFFS, 32'($urandom_range(0, 102400) - 51200));
          write_cfg(REG_INC_PER_HZ, $urandom);
        end
      endcase
      if (ph == 5) idle_off = 1'b1;
      for (i = 0; i < 125; i++) send_sample(rand_sample());
    end
    drain();
    if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
